// ----- design/slib_pkg.sv -----
// Shared types and constants for the serial line input buffer.
package slib_pkg;

	localparam int BYTE_W      = 8;
	localparam int LIMIT_W     = 7;
	localparam int OVR_W       = 16;
	localparam int MAX_RESULTS = 64;

	localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;
	localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;

	localparam logic [OVR_W-1:0] OVR_MAX = '1;

	// Request actions
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Configuration register indexes
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_ECHO   = 1'b1;

	typedef enum logic [2:0] {
		K_ECHO     = 3'd0,
		K_LINE     = 3'd1,
		K_NOTREADY = 3'd2,
		K_DISABLED = 3'd3,
		K_EMPTY    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		SEL_NONE    = 3'd0,
		SEL_ECHO    = 3'd1,
		SEL_ECHO_LF = 3'd2,
		SEL_STATUS  = 3'd3,
		SEL_STREAM  = 3'd4
	} out_sel_t;

	typedef struct packed {
		logic     byte_upd;
		logic     start_read;
		logic     clear_line;
		out_sel_t sel;
		kind_t    kind;
	} cmd_t;

	typedef struct packed {
		logic enable;
		logic echo;
		logic can_load;
		logic is_cr;
		logic line_ready;
		logic line_empty;
		logic stream_last;
	} stat_t;

endpackage

// ----- design/slib_if.sv -----
// Channel interfaces: request, result and configuration write.
interface slib_req_if;
	import slib_pkg::*;
	logic               valid;
	logic               ready;
	logic               action;
	logic [BYTE_W-1:0]  rx_byte;
	logic [LIMIT_W-1:0] read_limit;
	modport source(output valid, action, rx_byte, read_limit, input ready);
	modport sink(input valid, action, rx_byte, read_limit, output ready);
endinterface

interface slib_rsp_if;
	import slib_pkg::*;
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [BYTE_W-1:0] data;
	logic              last;
	logic [OVR_W-1:0]  overrun_count;
	modport source(output valid, kind, data, last, overrun_count, input ready);
	modport sink(input valid, kind, data, last, overrun_count, output ready);
endinterface

interface slib_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- design/slib_ctrl.sv -----
// Controller state machine: sequences echo, status and line streaming.
module slib_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_action,
	output logic           req_ready,
	input  slib_pkg::stat_t stat,
	output slib_pkg::cmd_t  cmd
);
	import slib_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_ECHO_LF  = 4'b0010,
		S_PREFETCH = 4'b0100,
		S_STREAM   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE) && stat.can_load;

	always_comb begin
		cmd.byte_upd   = 1'b0;
		cmd.start_read = 1'b0;
		cmd.clear_line = 1'b0;
		cmd.sel        = SEL_NONE;
		cmd.kind       = K_ECHO;
		state_d        = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && req_ready) begin
					if (req_action == ACT_BYTE) begin
						if (stat.enable) begin
							cmd.byte_upd = 1'b1;
							if (stat.echo) begin
								cmd.sel = SEL_ECHO;
								if (stat.is_cr)
									state_d = S_ECHO_LF;
							end
						end
					end else if (!stat.enable) begin
						cmd.sel  = SEL_STATUS;
						cmd.kind = K_DISABLED;
					end else if (!stat.line_ready) begin
						cmd.sel  = SEL_STATUS;
						cmd.kind = K_NOTREADY;
					end else if (stat.line_empty) begin
						cmd.sel        = SEL_STATUS;
						cmd.kind       = K_EMPTY;
						cmd.clear_line = 1'b1;
					end else begin
						cmd.start_read = 1'b1;
						cmd.clear_line = 1'b1;
						state_d        = S_PREFETCH;
					end
				end
			end
			S_ECHO_LF: begin
				if (stat.can_load) begin
					cmd.sel = SEL_ECHO_LF;
					state_d = S_IDLE;
				end
			end
			S_PREFETCH: begin
				state_d = S_STREAM;
			end
			S_STREAM: begin
				if (stat.can_load) begin
					cmd.sel  = SEL_STREAM;
					cmd.kind = K_LINE;
					if (stat.stream_last)
						state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- design/slib_dp.sv -----
// Datapath: line store memory, counters, config registers and result register.
module slib_dp #(
	parameter int LINE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_index,
	input  logic                           cfg_data,
	input  logic [slib_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [slib_pkg::LIMIT_W-1:0]   read_limit,
	input  slib_pkg::cmd_t                 cmd,
	output slib_pkg::stat_t                stat,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output slib_pkg::kind_t                rsp_kind,
	output logic [slib_pkg::BYTE_W-1:0]    rsp_data,
	output logic                           rsp_last,
	output logic [slib_pkg::OVR_W-1:0]     rsp_overrun_count
);
	import slib_pkg::*;

	localparam int AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CW    = $clog2(LINE_DEPTH + 1);
	localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int CAP   = (MAX_RESULTS < LINE_DEPTH) ? MAX_RESULTS : LINE_DEPTH;
	localparam logic [CW-1:0]    DEPTH_C = CW'(LINE_DEPTH);
	localparam logic [CMP_W-1:0] CAP_C   = CMP_W'(CAP);

	logic [BYTE_W-1:0] mem [LINE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic              enable_q;
	logic              echo_q;
	logic [CW-1:0]     fill_q;
	logic              line_ended_q;
	logic [OVR_W-1:0]  dropped_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     rem_q;
	logic              zero_seen_q;
	logic [OVR_W-1:0]  ovr_q;
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;
	logic [OVR_W-1:0]  out_ovr_q;

	logic [LIMIT_W-1:0] lim;
	logic [CMP_W-1:0]   fill_x;
	logic [CMP_W-1:0]   lim_x;
	logic               fill_ge;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   cnt_cap;
	logic               full;
	logic               is_cr;
	logic               is_del;
	logic               ends_line;
	logic [BYTE_W-1:0]  store_byte;
	logic [OVR_W-1:0]   dropped_d;
	logic               can_load;
	logic               stream_load;
	logic [AW-1:0]      rd_addr;
	logic [BYTE_W-1:0]  line_byte;

	always_comb begin
		lim        = (read_limit == '0) ? LIMIT_W'(1) : read_limit;
		fill_x     = CMP_W'(fill_q);
		lim_x      = CMP_W'(lim);
		fill_ge    = fill_x >= lim_x;
		cnt_x      = fill_ge ? (lim_x - CMP_W'(1)) : fill_x;
		cnt_cap    = (cnt_x > CAP_C) ? CAP_C : cnt_x;
		full       = (fill_q == DEPTH_C);
		is_cr      = (rx_byte == CH_CR);
		is_del     = (rx_byte == CH_DEL) || (rx_byte == CH_BS);
		ends_line  = is_cr || (rx_byte == CH_LF);
		store_byte = is_cr ? CH_LF : rx_byte;
		dropped_d  = dropped_q;
		if (cmd.byte_upd && full && (dropped_q != OVR_MAX))
			dropped_d = dropped_q + OVR_W'(1);
		can_load    = !out_valid_q || rsp_ready;
		stream_load = (cmd.sel == SEL_STREAM);
		// read one word ahead so streaming runs at one word per cycle while the output is not stalled
		rd_addr     = stream_load ? (idx_q + AW'(1)) : idx_q;
		line_byte   = zero_seen_q ? '0 : rd_data_q;
	end

	always_comb begin
		stat.enable      = enable_q;
		stat.echo        = echo_q;
		stat.can_load    = can_load;
		stat.is_cr       = is_cr;
		stat.line_ready  = line_ended_q || fill_ge;
		stat.line_empty  = (cnt_cap == '0);
		stat.stream_last = (rem_q == CW'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_upd && !full && !is_del)
			mem[fill_q[AW-1:0]] <= store_byte;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			echo_q       <= 1'b0;
			fill_q       <= '0;
			line_ended_q <= 1'b0;
			dropped_q    <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			zero_seen_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ENABLE)
					enable_q <= cfg_data;
				else
					echo_q <= cfg_data;
			end
			if (cmd.byte_upd) begin
				dropped_q <= dropped_d;
				if (!full) begin
					if (ends_line)
						line_ended_q <= 1'b1;
					if (is_del) begin
						if (fill_q != '0)
							fill_q <= fill_q - CW'(1);
					end else begin
						fill_q <= fill_q + CW'(1);
					end
				end
			end
			if (cmd.clear_line) begin
				fill_q       <= '0;
				line_ended_q <= 1'b0;
				dropped_q    <= '0;
			end
			if (cmd.start_read) begin
				idx_q       <= '0;
				rem_q       <= CW'(cnt_cap);
				zero_seen_q <= 1'b0;
			end else if (stream_load) begin
				idx_q <= idx_q + AW'(1);
				rem_q <= rem_q - CW'(1);
				if (line_byte == '0)
					zero_seen_q <= 1'b1;
			end
			if (cmd.sel != SEL_NONE)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_read)
			ovr_q <= dropped_q;
		case (cmd.sel)
			SEL_ECHO: begin
				out_kind_q <= K_ECHO;
				out_data_q <= rx_byte;
				out_last_q <= !is_cr;
				out_ovr_q  <= dropped_d;
			end
			SEL_ECHO_LF: begin
				out_kind_q <= K_ECHO;
				out_data_q <= CH_LF;
				out_last_q <= 1'b1;
				out_ovr_q  <= dropped_q;
			end
			SEL_STATUS: begin
				out_kind_q <= cmd.kind;
				out_data_q <= '0;
				out_last_q <= 1'b1;
				out_ovr_q  <= dropped_q;
			end
			SEL_STREAM: begin
				out_kind_q <= K_LINE;
				out_data_q <= line_byte;
				out_last_q <= (rem_q == CW'(1));
				out_ovr_q  <= ovr_q;
			end
			default: begin
				// hold
			end
		endcase
	end

	assign rsp_valid         = out_valid_q;
	assign rsp_kind          = out_kind_q;
	assign rsp_data          = out_data_q;
	assign rsp_last          = out_last_q;
	assign rsp_overrun_count = out_ovr_q;

endmodule

// ----- design/serial_line_input_buffer.sv -----
// Top level of the serial line input buffer: controller plus datapath.
// A status request, or a byte request while enabled with echo on, loads its result word at the
// accepting edge; a line read passes the prefetch state before the stream state loads its first
// word. Throughput: one received byte or streamed word per cycle while the output is free; an
// echoed carriage return also passes the echo line-feed state. A request is taken in the idle
// state once the output register is free or drains on the same edge. Reset clears config,
// fill count, end-of-line and overrun count; the line store is not cleared.
module serial_line_input_buffer #(
	parameter int LINE_DEPTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	slib_cfg_if.sink    cfg,
	slib_req_if.sink    req,
	slib_rsp_if.source  rsp
);
	import slib_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	slib_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	slib_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.rx_byte           (req.rx_byte),
		.read_limit        (req.read_limit),
		.cmd               (cmd),
		.stat              (stat),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_kind          (rsp.kind),
		.rsp_data          (rsp.data),
		.rsp_last          (rsp.last),
		.rsp_overrun_count (rsp.overrun_count)
	);

endmodule

// ----- design/slib_chk.sv -----
// Port-level checker for the serial line input buffer and its bind.
module slib_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_action,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input slib_pkg::kind_t             rsp_kind,
	input logic [slib_pkg::BYTE_W-1:0] rsp_data,
	input logic                        rsp_last,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        cfg_index,
	input logic                        cfg_data
);
	import slib_pkg::*;

	logic en_q;

	// track the enable register as written through the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			en_q <= 1'b0;
		else if (cfg_valid && cfg_ready && (cfg_index == REG_ENABLE))
			en_q <= cfg_data;
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
			$stable(rsp_data) && $stable(rsp_last))
		else $error("result word changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid || rsp_ready)
		else $error("request taken while a result word is stuck");

	a_disabled_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_action == ACT_READ) && !en_q |=>
			rsp_valid && (rsp_kind == K_DISABLED) && rsp_last)
		else $error("read while disabled did not report disabled");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_kind == K_NOTREADY) || (rsp_kind == K_DISABLED) ||
			(rsp_kind == K_EMPTY)) |-> (rsp_data == '0) && rsp_last)
		else $error("status word carries data or is not last");

endmodule

bind serial_line_input_buffer slib_chk u_slib_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_kind   (rsp.kind),
	.rsp_data   (rsp.data),
	.rsp_last   (rsp.last),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.cfg_index  (cfg.index),
	.cfg_data   (cfg.data)
);
